### design/dios_pkg.sv
// Shared types and constants of the depth indexed operand stack.
// Holds command and error codes, controller/datapath structs and state codes.
// No dependencies.
package dios_pkg;

	// Stack geometry, fixed by the field widths of the beat format
	localparam int STACK_DEPTH   = 64;
	localparam int ELEMENT_BYTES = 8;
	localparam int DATA_W        = 8 * ELEMENT_BYTES;
	localparam int LEN_W         = 4;
	localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W        = $clog2(STACK_DEPTH);
	localparam int ENTRY_W       = LEN_W + DATA_W;
	localparam int ERR_W         = 2;
	localparam int CMD_W         = 3;

	// Stream widths: fields packed from bit zero, padded to whole bytes
	localparam int S_TDATA_W = 80;
	localparam int S_TUSER_W = CMD_W;
	localparam int M_TDATA_W = 80;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH = 3'd0,
		CMD_POP  = 3'd1,
		CMD_PEEK = 3'd2,
		CMD_PICK = 3'd3,
		CMD_DROP = 3'd4,
		CMD_SWAP = 3'd5,
		CMD_ROT  = 3'd6,
		CMD_ROLL = 3'd7
	} cmd_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK    = 2'd0,
		ERR_UNDER = 2'd1,
		ERR_OVER  = 2'd2
	} err_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SAVE,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_RESP
	} state_t;

	typedef enum logic [1:0] {
		RSRC_ITEM,
		RSRC_START,
		RSRC_NEXT
	} rd_src_t;

	typedef enum logic [2:0] {
		WR_NONE,
		WR_PUSH,
		WR_PICK,
		WR_SHIFT,
		WR_FINAL
	} wr_sel_t;

	typedef enum logic [1:0] {
		CNT_HOLD,
		CNT_INC,
		CNT_DEC,
		CNT_SUB_N
	} cnt_op_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    load_item;
		logic    set_err;
		logic    rd_en;
		rd_src_t rd_src;
		wr_sel_t wr_sel;
		cnt_op_t cnt_op;
		logic    cap_read;
		logic    move_init;
		logic    save;
		logic    step;
		logic    load_out;
	} dp_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		cmd_t cmd;
		err_t err;
		logic move_trivial;
		logic at_final;
	} dp_stat_t;

endpackage

### design/depth_indexed_operand_stack_top.sv
// Top level of the depth indexed operand stack: stream ports, controller and
// datapath. Depends on dios_pkg, dios_ctrl, dios_dp (and dios_ram below it).
//
// Operand stack of up to 64 elements, each up to 8 bytes with a byte length,
// held in a single-port-read RAM. One command is accepted per beat on the
// slave stream and exactly one result beat comes out on the master stream, in
// order. Push, drop and any failed command go from decode straight to the
// result; pop, peek and pick first read the RAM; swap, rot n and roll at depth
// d save one entry, shift k elements (1 for swap, n-1 for rot, d for roll),
// each read and written back in turn through the one RAM read port, and then
// write the saved entry to its final slot. A rot with count 0 or 1 moves
// nothing. The next command is accepted once the previous one is in the output
// register, even while that result still waits for m_tready. The entry store
// is not cleared at reset; no clearing pass is needed.
module depth_indexed_operand_stack_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// depth_or_count[6:0], push_data[70:7], push_length[74:71], zero pad
	input  logic [dios_pkg::S_TDATA_W-1:0]    s_tdata,
	// cmd[2:0]
	input  logic [dios_pkg::S_TUSER_W-1:0]    s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// read_data[63:0], read_length[67:64], error_code[69:68], stack_size[76:70], zero pad
	output logic [dios_pkg::M_TDATA_W-1:0]    m_tdata
);
	import dios_pkg::*;

	localparam int IN_N_LO   = 0;
	localparam int IN_D_LO   = IN_N_LO + CNT_W;
	localparam int IN_L_LO   = IN_D_LO + DATA_W;
	localparam int OUT_USED  = DATA_W + LEN_W + ERR_W + CNT_W;

	dp_ctl_t            ctl;
	dp_stat_t           stat;
	logic [DATA_W-1:0]  read_data;
	logic [LEN_W-1:0]   read_length;
	logic [ERR_W-1:0]   error_code;
	logic [CNT_W-1:0]   stack_size;

	dios_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctl      (ctl)
	);

	dios_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.stat           (stat),
		.item_cmd       (cmd_t'(s_tuser[CMD_W-1:0])),
		.depth_or_count (s_tdata[IN_N_LO +: CNT_W]),
		.push_data      (s_tdata[IN_D_LO +: DATA_W]),
		.push_length    (s_tdata[IN_L_LO +: LEN_W]),
		.read_data      (read_data),
		.read_length    (read_length),
		.error_code     (error_code),
		.stack_size     (stack_size)
	);

	// Pack the result beat
	assign m_tdata = {{(M_TDATA_W - OUT_USED){1'b0}}, stack_size, error_code,
		read_length, read_data};

endmodule

### design/dios_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the stack entry store.
module dios_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### design/dios_dp.sv
// Datapath of the operand stack: item registers, element count, move pointers,
// result and output registers, and the entry RAM. Depends on dios_pkg, dios_ram.
module dios_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dios_pkg::dp_ctl_t             ctl,
	output dios_pkg::dp_stat_t            stat,
	input  dios_pkg::cmd_t                item_cmd,
	input  logic [dios_pkg::CNT_W-1:0]    depth_or_count,
	input  logic [dios_pkg::DATA_W-1:0]   push_data,
	input  logic [dios_pkg::LEN_W-1:0]    push_length,
	output logic [dios_pkg::DATA_W-1:0]   read_data,
	output logic [dios_pkg::LEN_W-1:0]    read_length,
	output logic [dios_pkg::ERR_W-1:0]    error_code,
	output logic [dios_pkg::CNT_W-1:0]    stack_size
);
	import dios_pkg::*;

	cmd_t               cmd_q;
	logic [CNT_W-1:0]   n_q;
	logic [DATA_W-1:0]  pdata_q;
	logic [LEN_W-1:0]   plen_q;
	logic [CNT_W-1:0]   count_q;
	logic [DATA_W-1:0]  res_data_q;
	logic [LEN_W-1:0]   res_len_q;
	err_t               res_err_q;
	logic [ADDR_W-1:0]  p_q;
	logic [ADDR_W-1:0]  f_q;
	logic               up_q;
	logic [ENTRY_W-1:0] save_q;
	logic [DATA_W-1:0]  out_data_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [ERR_W-1:0]   out_err_q;
	logic [CNT_W-1:0]   out_size_q;

	logic [CNT_W-1:0]   top_slot;
	logic [CNT_W-1:0]   depth_slot;
	logic [CNT_W-1:0]   rot_slot;
	logic               full;
	err_t               err;
	logic [ADDR_W-1:0]  item_addr;
	logic [ADDR_W-1:0]  start_addr;
	logic [ADDR_W-1:0]  final_addr;
	logic               start_up;
	logic [ADDR_W-1:0]  next_addr;
	logic [LEN_W-1:0]   len_sat;
	logic [DATA_W-1:0]  data_masked;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] rd_data;
	logic [ADDR_W-1:0]  rd_addr;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	// Slot arithmetic on the current count
	assign top_slot   = count_q - CNT_W'(1);
	assign depth_slot = count_q - CNT_W'(1) - n_q;
	assign rot_slot   = count_q - n_q;
	assign full       = (count_q >= CNT_W'(STACK_DEPTH));

	// Range checks per command
	always_comb begin
		err = ERR_OK;
		unique case (cmd_q)
			CMD_PUSH: if (full) err = ERR_OVER;
			CMD_POP:  if (count_q == '0) err = ERR_UNDER;
			CMD_PEEK: if (n_q >= count_q) err = ERR_UNDER;
			CMD_PICK: begin
				if (n_q >= count_q) err = ERR_UNDER;
				else if (full) err = ERR_OVER;
			end
			CMD_DROP: if (n_q > count_q) err = ERR_UNDER;
			CMD_SWAP: if (count_q < CNT_W'(2)) err = ERR_UNDER;
			CMD_ROT:  if (n_q > count_q) err = ERR_UNDER;
			CMD_ROLL: if (n_q >= count_q) err = ERR_UNDER;
		endcase
	end

	// Move bounds: roll and swap walk up toward the top, rot walks down
	always_comb begin
		start_addr = depth_slot[ADDR_W-1:0];
		final_addr = top_slot[ADDR_W-1:0];
		start_up   = 1'b1;
		unique case (cmd_q)
			CMD_SWAP: start_addr = ADDR_W'(count_q - CNT_W'(2));
			CMD_ROT: begin
				start_addr = top_slot[ADDR_W-1:0];
				final_addr = rot_slot[ADDR_W-1:0];
				start_up   = 1'b0;
			end
			default: ;
		endcase
	end

	assign item_addr = (cmd_q == CMD_POP) ? top_slot[ADDR_W-1:0] : depth_slot[ADDR_W-1:0];
	assign next_addr = up_q ? (p_q + ADDR_W'(1)) : (p_q - ADDR_W'(1));

	assign stat.cmd          = cmd_q;
	assign stat.err          = err;
	assign stat.move_trivial = (cmd_q == CMD_ROT) && (n_q <= CNT_W'(1));
	assign stat.at_final     = (p_q == f_q);

	// Saturate the length and clear bytes beyond it
	always_comb begin
		len_sat = (plen_q > LEN_W'(ELEMENT_BYTES)) ? LEN_W'(ELEMENT_BYTES) : plen_q;
		for (int i = 0; i < ELEMENT_BYTES; i++) begin
			data_masked[8*i +: 8] = (LEN_W'(i) < len_sat) ? pdata_q[8*i +: 8] : 8'h00;
		end
	end
	assign push_entry = {len_sat, data_masked};

	// Read address select
	always_comb begin
		unique case (ctl.rd_src)
			RSRC_ITEM:  rd_addr = item_addr;
			RSRC_START: rd_addr = start_addr;
			RSRC_NEXT:  rd_addr = next_addr;
			default:    rd_addr = item_addr;
		endcase
	end

	// Write port select
	always_comb begin
		wr_en   = 1'b1;
		wr_addr = count_q[ADDR_W-1:0];
		wr_data = push_entry;
		unique case (ctl.wr_sel)
			WR_NONE:  wr_en = 1'b0;
			WR_PUSH:  ;
			WR_PICK:  wr_data = rd_data;
			WR_SHIFT: begin
				wr_addr = p_q;
				wr_data = rd_data;
			end
			WR_FINAL: begin
				wr_addr = f_q;
				wr_data = save_q;
			end
			default:  wr_en = 1'b0;
		endcase
	end

	dios_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (ctl.rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			unique case (ctl.cnt_op)
				CNT_HOLD:  ;
				CNT_INC:   count_q <= count_q + CNT_W'(1);
				CNT_DEC:   count_q <= count_q - CNT_W'(1);
				CNT_SUB_N: count_q <= count_q - n_q;
			endcase
		end
	end

	// Command register, held at a known command out of reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q <= CMD_PUSH;
		end else if (ctl.load_item) begin
			cmd_q <= item_cmd;
		end
	end

	// Item, result, pointer and output payload registers
	always_ff @(posedge clk) begin
		if (ctl.load_item) begin
			n_q     <= depth_or_count;
			pdata_q <= push_data;
			plen_q  <= push_length;
		end
		if (ctl.set_err) begin
			res_err_q  <= err;
			res_data_q <= '0;
			res_len_q  <= '0;
		end
		if (ctl.cap_read) begin
			res_data_q <= rd_data[DATA_W-1:0];
			res_len_q  <= rd_data[ENTRY_W-1:DATA_W];
		end
		if (ctl.move_init) begin
			p_q  <= start_addr;
			f_q  <= final_addr;
			up_q <= start_up;
		end else if (ctl.step) begin
			p_q <= next_addr;
		end
		if (ctl.save) begin
			save_q <= rd_data;
		end
		if (ctl.load_out) begin
			out_data_q <= res_data_q;
			out_len_q  <= res_len_q;
			out_err_q  <= res_err_q;
			out_size_q <= count_q;
		end
	end

	assign read_data   = out_data_q;
	assign read_length = out_len_q;
	assign error_code  = out_err_q;
	assign stack_size  = out_size_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(STACK_DEPTH))
		else $error("element count above stack depth");

	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.cnt_op == CNT_INC |-> !full)
		else $error("count increment on a full stack");

	a_shift_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_sel == WR_SHIFT |-> CNT_W'(p_q) < count_q)
		else $error("shift write beyond the live elements");
`endif

endmodule

### design/dios_ctrl.sv
// Controller state machine of the operand stack: handshakes, command sequencing
// and the element move loop. Depends on dios_pkg.
module dios_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  dios_pkg::dp_stat_t  stat,
	output dios_pkg::dp_ctl_t   ctl
);
	import dios_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (s_tvalid) state_d = S_DECODE;
			S_DECODE: begin
				if (stat.err != ERR_OK) begin
					state_d = S_RESP;
				end else begin
					unique case (stat.cmd)
						CMD_PUSH, CMD_DROP: state_d = S_RESP;
						CMD_POP, CMD_PEEK, CMD_PICK: state_d = S_READ;
						CMD_SWAP, CMD_ROT, CMD_ROLL: begin
							state_d = stat.move_trivial ? S_RESP : S_SAVE;
						end
					endcase
				end
			end
			S_READ:     state_d = S_RESP;
			S_SAVE:     state_d = S_SHIFT_RD;
			S_SHIFT_RD: state_d = stat.at_final ? S_RESP : S_SHIFT_WR;
			S_SHIFT_WR: state_d = S_SHIFT_RD;
			S_RESP:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		ctl = '{load_item: 1'b0, set_err: 1'b0, rd_en: 1'b0, rd_src: RSRC_ITEM,
			wr_sel: WR_NONE, cnt_op: CNT_HOLD, cap_read: 1'b0, move_init: 1'b0,
			save: 1'b0, step: 1'b0, load_out: 1'b0};
		unique case (state_q)
			S_IDLE: ctl.load_item = s_tvalid;
			S_DECODE: begin
				ctl.set_err = 1'b1;
				if (stat.err == ERR_OK) begin
					unique case (stat.cmd)
						CMD_PUSH: begin
							ctl.wr_sel = WR_PUSH;
							ctl.cnt_op = CNT_INC;
						end
						CMD_DROP: ctl.cnt_op = CNT_SUB_N;
						CMD_POP, CMD_PEEK, CMD_PICK: begin
							ctl.rd_en  = 1'b1;
							ctl.rd_src = RSRC_ITEM;
						end
						CMD_SWAP, CMD_ROT, CMD_ROLL: begin
							if (!stat.move_trivial) begin
								ctl.rd_en     = 1'b1;
								ctl.rd_src    = RSRC_START;
								ctl.move_init = 1'b1;
							end
						end
					endcase
				end
			end
			S_READ: begin
				unique case (stat.cmd)
					CMD_POP: begin
						ctl.cap_read = 1'b1;
						ctl.cnt_op   = CNT_DEC;
					end
					CMD_PEEK: ctl.cap_read = 1'b1;
					CMD_PICK: begin
						ctl.wr_sel = WR_PICK;
						ctl.cnt_op = CNT_INC;
					end
					default: ;
				endcase
			end
			S_SAVE: ctl.save = 1'b1;
			S_SHIFT_RD: begin
				if (stat.at_final) begin
					ctl.wr_sel = WR_FINAL;
				end else begin
					ctl.rd_en  = 1'b1;
					ctl.rd_src = RSRC_NEXT;
				end
			end
			S_SHIFT_WR: begin
				ctl.wr_sel = WR_SHIFT;
				ctl.step   = 1'b1;
			end
			S_RESP: ctl.load_out = out_free;
			default: ;
		endcase
	end

	// State and output valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q == S_DECODE)
		else $error("accepted beat not decoded next cycle");

	a_error_resp: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DECODE && stat.err != ERR_OK |=> state_q == S_RESP)
		else $error("failed command did not go straight to result");

	a_resp_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESP && out_free |=> state_q == S_IDLE && out_valid_q)
		else $error("result not presented after response");
`endif

endmodule
